### rtl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg: shared types and constants of the barometer compensation block
// Field widths, fixed-point shifts, register indexes, sequencer states and
// the command word passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package btc_pkg;

  // Field and register widths
  localparam int unsigned RAW_W   = 24;  // raw converter sample
  localparam int unsigned CAL_W   = 16;  // calibration word
  localparam int unsigned IDX_W   = 3;   // configuration register index
  localparam int unsigned DT_W    = 25;  // temperature difference
  localparam int unsigned TEMP_W  = 20;  // temperature in centidegrees
  localparam int unsigned PRESS_W = 32;  // pressure in pascal

  // Internal widths
  localparam int unsigned MUL_W   = 26;           // multiplier operand
  localparam int unsigned PROD_W  = 2 * MUL_W;    // multiplier product
  localparam int unsigned WIDE_W  = 40;           // offset and sensitivity
  localparam int unsigned ACC_W   = 64;           // pressure product
  localparam int unsigned X_W     = 45;           // scaled pressure before last shift
  localparam int unsigned SQ_W    = 34;           // square of a temperature distance
  localparam int unsigned T2_W    = 18;           // second-order temperature term
  localparam int unsigned SPLIT_W = 20;           // low part of sensitivity operand

  // Fixed-point shifts
  localparam int unsigned REF_TEMP_SH  = 8;
  localparam int unsigned OFF_BASE_SH  = 16;
  localparam int unsigned SENS_BASE_SH = 15;
  localparam int unsigned OFF_TC_SH    = 7;
  localparam int unsigned SENS_TC_SH   = 8;
  localparam int unsigned TEMP_SH      = 23;
  localparam int unsigned T2_SH        = 31;
  localparam int unsigned SENS_DIV_SH  = 21;
  localparam int unsigned PRESS_DIV_SH = 15;

  // Temperature thresholds in centidegrees
  localparam logic signed [TEMP_W-1:0] TEMP_REF_CENTI = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_CENTI = -20'sd1500;

  // Input command codes
  localparam logic CMD_PRESSURE    = 1'b0;
  localparam logic CMD_TEMPERATURE = 1'b1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_SENS_BASE     = 3'd0;
  localparam logic [IDX_W-1:0] CFG_OFFSET_BASE   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SENS_TEMPCO   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_OFFSET_TEMPCO = 3'd3;
  localparam logic [IDX_W-1:0] CFG_REF_TEMP      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_TEMP_SLOPE    = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DT,
    ST_MC4,
    ST_MC3,
    ST_MC6,
    ST_MDT,
    ST_T2,
    ST_MD1,
    ST_MD2,
    ST_SQ2,
    ST_SUB,
    ST_MPL,
    ST_MPH,
    ST_ACC,
    ST_RND,
    ST_X,
    ST_OUT
  } ctl_state_e;

  typedef enum logic [2:0] {
    MUL_C4_DT,
    MUL_C3_DT,
    MUL_C6_DT,
    MUL_DT_DT,
    MUL_D1_D1,
    MUL_D2_D2,
    MUL_P_LO,
    MUL_P_HI
  } mul_sel_e;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_DT,
    STEP_OFF,
    STEP_SENS,
    STEP_TEMP,
    STEP_T2,
    STEP_SQ1,
    STEP_SQ2,
    STEP_SUB,
    STEP_ACC_LO,
    STEP_ACC_HI,
    STEP_RND,
    STEP_X
  } dp_step_e;

  typedef struct packed {
    logic       load_pres;
    logic       load_raw;
    logic       load_out;
    mul_sel_e   mul_sel;
    dp_step_e   step;
  } ctl_cmd_t;

endpackage

### rtl/btc_if.sv
// ----------------------------------------------------------------------------
// btc_if: sample and result channels of the barometer compensation block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface btc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [btc_pkg::RAW_W-1:0]   raw_sample;

  modport source (output valid, command, raw_sample, input ready);
  modport sink   (input valid, command, raw_sample, output ready);
endinterface

interface btc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [btc_pkg::TEMP_W-1:0]  temperature_centi;
  logic signed [btc_pkg::PRESS_W-1:0] pressure_pa;
  logic signed [btc_pkg::DT_W-1:0]    temp_delta;

  modport source (output valid, temperature_centi, pressure_pa, temp_delta, input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, temp_delta, output ready);
endinterface

### rtl/barometer_temperature_compensation.sv
// ----------------------------------------------------------------------------
// barometer_temperature_compensation: second-order barometer compensation
// Turns raw pressure and temperature converter samples into a compensated
// temperature and a saturated pressure using six calibration words.
// ----------------------------------------------------------------------------
// Usage
//   in_i   : sample channel. command 0 stores raw_sample as the pressure
//            sample and gives no result; command 1 takes raw_sample as the
//            temperature sample and starts a computation.
//   out_o  : one result per temperature sample: temperature_centi,
//            pressure_pa and temp_delta.
//   cfg_*  : write port for the six calibration words (index 0 to 5); write
//            only while no computation is in flight. Other indexes are dropped.
// Timing
//   A pressure sample is stored as it is taken; back-to-back pressure transfers
//   run at one per cycle while the sequencer is idle. A temperature sample is
//   worked through 16 steps of the sequencer, and no new sample of either kind
//   is taken until its result has been handed to the output register. The step
//   count is set by the single shared 26x26 multiplier, used eight times in
//   sequence, and the rounding steps between its uses.
//   If the receiver stalls, a finished result waits in the output register;
//   new samples are still taken, and a second result waits in the last step.
// Reset
//   Clears the calibration words and the stored pressure sample to zero.
// ----------------------------------------------------------------------------
module barometer_temperature_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [btc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [btc_pkg::CAL_W-1:0]  cfg_wdata_i,
  btc_in_if.sink                     in_i,
  btc_out_if.source                  out_o
);

  btc_pkg::ctl_cmd_t cmd;
  logic              in_ready;
  logic              out_valid;

  btc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .cmd_o        (cmd)
  );

  btc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (cmd),
    .raw_sample_i        (in_i.raw_sample),
    .temperature_centi_o (out_o.temperature_centi),
    .pressure_pa_o       (out_o.pressure_pa),
    .temp_delta_o        (out_o.temp_delta)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

### rtl/btc_ctrl.sv
// ----------------------------------------------------------------------------
// btc_ctrl: compensation sequencer
// Walks one temperature sample through the datapath steps, one step a cycle
// (the last waits for a free result register); owns input ready, result valid.
// ----------------------------------------------------------------------------
module btc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_command_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output btc_pkg::ctl_cmd_t cmd_o
);

  btc_pkg::ctl_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btc_pkg::ST_IDLE: begin
        if (in_valid_i && in_command_i == btc_pkg::CMD_TEMPERATURE) begin
          state_d = btc_pkg::ST_DT;
        end
      end
      btc_pkg::ST_DT:  state_d = btc_pkg::ST_MC4;
      btc_pkg::ST_MC4: state_d = btc_pkg::ST_MC3;
      btc_pkg::ST_MC3: state_d = btc_pkg::ST_MC6;
      btc_pkg::ST_MC6: state_d = btc_pkg::ST_MDT;
      btc_pkg::ST_MDT: state_d = btc_pkg::ST_T2;
      btc_pkg::ST_T2:  state_d = btc_pkg::ST_MD1;
      btc_pkg::ST_MD1: state_d = btc_pkg::ST_MD2;
      btc_pkg::ST_MD2: state_d = btc_pkg::ST_SQ2;
      btc_pkg::ST_SQ2: state_d = btc_pkg::ST_SUB;
      btc_pkg::ST_SUB: state_d = btc_pkg::ST_MPL;
      btc_pkg::ST_MPL: state_d = btc_pkg::ST_MPH;
      btc_pkg::ST_MPH: state_d = btc_pkg::ST_ACC;
      btc_pkg::ST_ACC: state_d = btc_pkg::ST_RND;
      btc_pkg::ST_RND: state_d = btc_pkg::ST_X;
      btc_pkg::ST_X:   state_d = btc_pkg::ST_OUT;
      btc_pkg::ST_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          state_d = btc_pkg::ST_IDLE;
        end
      end
      default: state_d = btc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.load_pres   = 1'b0;
    cmd_o.load_raw    = 1'b0;
    cmd_o.load_out    = 1'b0;
    cmd_o.mul_sel     = btc_pkg::MUL_C4_DT;
    cmd_o.step        = btc_pkg::STEP_NONE;
    unique case (state_q)
      btc_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_pres = in_valid_i && in_command_i == btc_pkg::CMD_PRESSURE;
        cmd_o.load_raw  = in_valid_i && in_command_i == btc_pkg::CMD_TEMPERATURE;
      end
      btc_pkg::ST_DT:  cmd_o.step = btc_pkg::STEP_DT;
      btc_pkg::ST_MC4: cmd_o.mul_sel = btc_pkg::MUL_C4_DT;
      btc_pkg::ST_MC3: begin
        cmd_o.mul_sel = btc_pkg::MUL_C3_DT;
        cmd_o.step    = btc_pkg::STEP_OFF;
      end
      btc_pkg::ST_MC6: begin
        cmd_o.mul_sel = btc_pkg::MUL_C6_DT;
        cmd_o.step    = btc_pkg::STEP_SENS;
      end
      btc_pkg::ST_MDT: begin
        cmd_o.mul_sel = btc_pkg::MUL_DT_DT;
        cmd_o.step    = btc_pkg::STEP_TEMP;
      end
      btc_pkg::ST_T2:  cmd_o.step = btc_pkg::STEP_T2;
      btc_pkg::ST_MD1: cmd_o.mul_sel = btc_pkg::MUL_D1_D1;
      btc_pkg::ST_MD2: begin
        cmd_o.mul_sel = btc_pkg::MUL_D2_D2;
        cmd_o.step    = btc_pkg::STEP_SQ1;
      end
      btc_pkg::ST_SQ2: cmd_o.step = btc_pkg::STEP_SQ2;
      btc_pkg::ST_SUB: cmd_o.step = btc_pkg::STEP_SUB;
      btc_pkg::ST_MPL: cmd_o.mul_sel = btc_pkg::MUL_P_LO;
      btc_pkg::ST_MPH: begin
        cmd_o.mul_sel = btc_pkg::MUL_P_HI;
        cmd_o.step    = btc_pkg::STEP_ACC_LO;
      end
      btc_pkg::ST_ACC: cmd_o.step = btc_pkg::STEP_ACC_HI;
      btc_pkg::ST_RND: cmd_o.step = btc_pkg::STEP_RND;
      btc_pkg::ST_X:   cmd_o.step = btc_pkg::STEP_X;
      btc_pkg::ST_OUT: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_temp_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_command_i == btc_pkg::CMD_TEMPERATURE)
      |=> state_q == btc_pkg::ST_DT)
    else $error("temperature transfer did not start the sequence");

  a_pres_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_command_i == btc_pkg::CMD_PRESSURE)
      |=> state_q == btc_pkg::ST_IDLE)
    else $error("pressure transfer started a computation");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == btc_pkg::ST_OUT)
    else $error("result raised outside the final step");

endmodule

### rtl/btc_dp.sv
// ----------------------------------------------------------------------------
// btc_dp: compensation datapath
// Calibration registers, stored pressure sample, one shared 26x26 multiplier
// with a registered product, and the accumulators for the compensation terms.
// ----------------------------------------------------------------------------
module btc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [btc_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [btc_pkg::CAL_W-1:0]         cfg_wdata_i,
  input  btc_pkg::ctl_cmd_t                 cmd_i,
  input  logic [btc_pkg::RAW_W-1:0]         raw_sample_i,
  output logic signed [btc_pkg::TEMP_W-1:0] temperature_centi_o,
  output logic signed [btc_pkg::PRESS_W-1:0] pressure_pa_o,
  output logic signed [btc_pkg::DT_W-1:0]   temp_delta_o
);

  localparam int unsigned ACC_W   = btc_pkg::ACC_W;
  localparam int unsigned PROD_W  = btc_pkg::PROD_W;
  localparam int unsigned MUL_W   = btc_pkg::MUL_W;
  localparam int unsigned WIDE_W  = btc_pkg::WIDE_W;
  localparam int unsigned TEMP_W  = btc_pkg::TEMP_W;
  localparam int unsigned DT_W    = btc_pkg::DT_W;
  localparam int unsigned RAW_W   = btc_pkg::RAW_W;
  localparam int unsigned CAL_W   = btc_pkg::CAL_W;
  localparam int unsigned X_W     = btc_pkg::X_W;
  localparam int unsigned SPLIT_W = btc_pkg::SPLIT_W;
  localparam int unsigned HI_W    = WIDE_W - SPLIT_W;
  localparam int unsigned PRESS_W = btc_pkg::PRESS_W;

  localparam logic signed [ACC_W-1:0] PRESS_MAX =
    {{(ACC_W-PRESS_W+1){1'b0}}, {(PRESS_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] PRESS_MIN =
    {{(ACC_W-PRESS_W+1){1'b1}}, {(PRESS_W-1){1'b0}}};

  // Signed shift right that rounds toward zero
  function automatic logic signed [ACC_W-1:0] trunc_shift(
    input logic signed [ACC_W-1:0] x,
    input int unsigned             sh
  );
    logic [ACC_W-1:0] low_mask;
    logic             round_up;
    low_mask = ~({ACC_W{1'b1}} << sh);
    round_up = x[ACC_W-1] && ((x & low_mask) != '0);
    return (x >>> sh) + signed'({{(ACC_W-1){1'b0}}, round_up});
  endfunction

  // Calibration registers
  logic [CAL_W-1:0] sens_base_q, offset_base_q, sens_tempco_q;
  logic [CAL_W-1:0] offset_tempco_q, ref_temp_q, temp_slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_base_q     <= '0;
      offset_base_q   <= '0;
      sens_tempco_q   <= '0;
      offset_tempco_q <= '0;
      ref_temp_q      <= '0;
      temp_slope_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btc_pkg::CFG_SENS_BASE:     sens_base_q     <= cfg_wdata_i;
        btc_pkg::CFG_OFFSET_BASE:   offset_base_q   <= cfg_wdata_i;
        btc_pkg::CFG_SENS_TEMPCO:   sens_tempco_q   <= cfg_wdata_i;
        btc_pkg::CFG_OFFSET_TEMPCO: offset_tempco_q <= cfg_wdata_i;
        btc_pkg::CFG_REF_TEMP:      ref_temp_q      <= cfg_wdata_i;
        btc_pkg::CFG_TEMP_SLOPE:    temp_slope_q    <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stored pressure sample
  logic [RAW_W-1:0] pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= '0;
    end else if (cmd_i.load_pres) begin
      pres_q <= raw_sample_i;
    end
  end

  // Working registers
  logic [RAW_W-1:0]                raw_q;
  logic signed [DT_W-1:0]          dt_q, dt_d;
  logic signed [WIDE_W-1:0]        off_q, off_d, sens_q, sens_d;
  logic [WIDE_W-1:0]               off2_q, off2_d, sens2_q, sens2_d;
  logic signed [TEMP_W-1:0]        temp_q, temp_d, d1_q, d1_d, d2_q, d2_d;
  logic [btc_pkg::T2_W-1:0]        t2_q, t2_d;
  logic                            lt20_q, lt20_d, lt15_q, lt15_d;
  logic signed [ACC_W-1:0]         acc_q, acc_d;
  logic signed [X_W-1:0]           x_q, x_d;
  logic signed [PROD_W-1:0]        prod_q;
  logic signed [MUL_W-1:0]         mul_a, mul_b;

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      btc_pkg::MUL_C4_DT: begin
        mul_a = {{(MUL_W-CAL_W){1'b0}}, offset_tempco_q};
        mul_b = {{(MUL_W-DT_W){dt_q[DT_W-1]}}, dt_q};
      end
      btc_pkg::MUL_C3_DT: begin
        mul_a = {{(MUL_W-CAL_W){1'b0}}, sens_tempco_q};
        mul_b = {{(MUL_W-DT_W){dt_q[DT_W-1]}}, dt_q};
      end
      btc_pkg::MUL_C6_DT: begin
        mul_a = {{(MUL_W-CAL_W){1'b0}}, temp_slope_q};
        mul_b = {{(MUL_W-DT_W){dt_q[DT_W-1]}}, dt_q};
      end
      btc_pkg::MUL_DT_DT: begin
        mul_a = {{(MUL_W-DT_W){dt_q[DT_W-1]}}, dt_q};
        mul_b = {{(MUL_W-DT_W){dt_q[DT_W-1]}}, dt_q};
      end
      btc_pkg::MUL_D1_D1: begin
        mul_a = {{(MUL_W-TEMP_W){d1_q[TEMP_W-1]}}, d1_q};
        mul_b = {{(MUL_W-TEMP_W){d1_q[TEMP_W-1]}}, d1_q};
      end
      btc_pkg::MUL_D2_D2: begin
        mul_a = {{(MUL_W-TEMP_W){d2_q[TEMP_W-1]}}, d2_q};
        mul_b = {{(MUL_W-TEMP_W){d2_q[TEMP_W-1]}}, d2_q};
      end
      btc_pkg::MUL_P_LO: begin
        mul_a = {{(MUL_W-RAW_W){1'b0}}, pres_q};
        mul_b = {{(MUL_W-SPLIT_W){1'b0}}, sens_q[SPLIT_W-1:0]};
      end
      btc_pkg::MUL_P_HI: begin
        mul_a = {{(MUL_W-RAW_W){1'b0}}, pres_q};
        mul_b = {{(MUL_W-HI_W){sens_q[WIDE_W-1]}}, sens_q[WIDE_W-1:SPLIT_W]};
      end
      default: ;
    endcase
  end

  // Derived views of the registered product
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] off_tc, sens_tc, temp_tc, press_full, acc_sh;
  logic [WIDE_W-1:0]       sq_w, sq5, sq7, sq11;

  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    off_tc   = trunc_shift(prod_ext, btc_pkg::OFF_TC_SH);
    sens_tc  = trunc_shift(prod_ext, btc_pkg::SENS_TC_SH);
    temp_tc  = trunc_shift(prod_ext, btc_pkg::TEMP_SH);
    acc_sh   = trunc_shift(acc_q, btc_pkg::SENS_DIV_SH);
    sq_w     = {{(WIDE_W-btc_pkg::SQ_W){1'b0}}, prod_q[btc_pkg::SQ_W-1:0]};
    sq5      = sq_w + (sq_w << 2);
    sq7      = (sq_w << 3) - sq_w;
    sq11     = (sq_w << 3) + (sq_w << 1) + sq_w;
    press_full = trunc_shift({{(ACC_W-X_W){x_q[X_W-1]}}, x_q}, btc_pkg::PRESS_DIV_SH);
  end

  // Step logic
  always_comb begin
    dt_d    = dt_q;
    off_d   = off_q;
    sens_d  = sens_q;
    off2_d  = off2_q;
    sens2_d = sens2_q;
    temp_d  = temp_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    t2_d    = t2_q;
    lt20_d  = lt20_q;
    lt15_d  = lt15_q;
    acc_d   = acc_q;
    x_d     = x_q;
    unique case (cmd_i.step)
      btc_pkg::STEP_NONE: ;
      btc_pkg::STEP_DT: begin
        dt_d = signed'({1'b0, raw_q})
             - signed'({1'b0, ref_temp_q, {btc_pkg::REF_TEMP_SH{1'b0}}});
      end
      btc_pkg::STEP_OFF: begin
        off_d = signed'(WIDE_W'({offset_base_q, {btc_pkg::OFF_BASE_SH{1'b0}}}))
              + off_tc[WIDE_W-1:0];
      end
      btc_pkg::STEP_SENS: begin
        sens_d = signed'(WIDE_W'({sens_base_q, {btc_pkg::SENS_BASE_SH{1'b0}}}))
               + sens_tc[WIDE_W-1:0];
      end
      btc_pkg::STEP_TEMP: begin
        temp_d = btc_pkg::TEMP_REF_CENTI + signed'(temp_tc[TEMP_W-1:0]);
      end
      btc_pkg::STEP_T2: begin
        lt20_d = temp_q < btc_pkg::TEMP_REF_CENTI;
        lt15_d = temp_q < btc_pkg::TEMP_LOW_CENTI;
        // dt squared is never negative: truncation is a plain shift
        t2_d   = (temp_q < btc_pkg::TEMP_REF_CENTI)
               ? prod_q[btc_pkg::T2_SH+btc_pkg::T2_W-1:btc_pkg::T2_SH] : '0;
        d1_d   = temp_q - btc_pkg::TEMP_REF_CENTI;
        d2_d   = temp_q - btc_pkg::TEMP_LOW_CENTI;
      end
      btc_pkg::STEP_SQ1: begin
        off2_d  = lt20_q ? (sq5 >> 1) : '0;
        sens2_d = lt20_q ? (sq5 >> 2) : '0;
      end
      btc_pkg::STEP_SQ2: begin
        if (lt15_q) begin
          off2_d  = off2_q + sq7;
          sens2_d = sens2_q + (sq11 >> 1);
        end
      end
      btc_pkg::STEP_SUB: begin
        off_d  = off_q - signed'(off2_q);
        sens_d = sens_q - signed'(sens2_q);
        temp_d = temp_q - signed'({{(TEMP_W-btc_pkg::T2_W){1'b0}}, t2_q});
      end
      btc_pkg::STEP_ACC_LO: begin
        acc_d = {{(ACC_W-RAW_W-SPLIT_W){1'b0}}, prod_q[RAW_W+SPLIT_W-1:0]};
      end
      btc_pkg::STEP_ACC_HI: begin
        acc_d = acc_q + (prod_ext <<< SPLIT_W);
      end
      btc_pkg::STEP_RND: begin
        x_d = acc_sh[X_W-1:0];
      end
      btc_pkg::STEP_X: begin
        x_d = x_q - {{(X_W-WIDE_W){off_q[WIDE_W-1]}}, off_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    dt_q    <= dt_d;
    off_q   <= off_d;
    sens_q  <= sens_d;
    off2_q  <= off2_d;
    sens2_q <= sens2_d;
    temp_q  <= temp_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    acc_q   <= acc_d;
    x_q     <= x_d;
    if (cmd_i.load_raw) begin
      raw_q <= raw_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_q   <= '0;
      lt20_q <= 1'b0;
      lt15_q <= 1'b0;
    end else begin
      t2_q   <= t2_d;
      lt20_q <= lt20_d;
      lt15_q <= lt15_d;
    end
  end

  // Result register; saturate pressure to the signed 32-bit range
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      temperature_centi_o <= temp_q;
      temp_delta_o        <= dt_q;
      if (press_full > PRESS_MAX) begin
        pressure_pa_o <= PRESS_MAX[PRESS_W-1:0];
      end else if (press_full < PRESS_MIN) begin
        pressure_pa_o <= PRESS_MIN[PRESS_W-1:0];
      end else begin
        pressure_pa_o <= press_full[PRESS_W-1:0];
      end
    end
  end

  a_cold_implies_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lt15_q |-> lt20_q)
    else $error("below -15 flag set without below 20 flag");

  a_t2_only_when_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lt20_q |-> t2_q == '0)
    else $error("second-order temperature term set above 20 degrees");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for barometer_temperature_compensation
// Drives pressure and temperature samples over the valid/ready channel,
// predicts each compensated reading in 64-bit integer arithmetic and checks
// the result stream in order, across several calibration settings.
// ----------------------------------------------------------------------------
module tb;
  import btc_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint RAW_MAX   = (64'sd1 << RAW_W) - 1;
  localparam longint TEMP_DIV  = 64'sd1 << TEMP_SH;
  localparam longint T2_DIV    = 64'sd1 << T2_SH;
  localparam longint SENS_DIV  = 64'sd1 << SENS_DIV_SH;
  localparam longint PRESS_DIV = 64'sd1 << PRESS_DIV_SH;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 288;

  typedef struct {
    logic signed [TEMP_W-1:0]  temp_centi;
    logic signed [PRESS_W-1:0] press_pa;
    logic signed [DT_W-1:0]    dt;
  } reading_t;

  class reading_checker;
    logic [CAL_W-1:0] cal [6];
    logic [RAW_W-1:0] stored_pressure;
    reading_t         expected_readings [$];
    int               errors;
    int               n_pressure;
    int               n_temperature;
    int               n_checked;
    int               n_cold;
    int               n_very_cold;

    function new();
      foreach (cal[i]) cal[i] = '0;
      stored_pressure = '0;
      errors = 0;
      n_pressure = 0;
      n_temperature = 0;
      n_checked = 0;
      n_cold = 0;
      n_very_cold = 0;
    endfunction

    function void write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] val);
      if (idx <= CFG_TEMP_SLOPE) cal[idx] = val;
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] raw);
      reading_t r;
      longint   raw_l, pres_l, c1, c2, c3, c4, c5, c6;
      longint   dt, temp, off, sens, off2, sens2, t2, d, press;
      raw_l  = raw;
      pres_l = stored_pressure;
      c1 = cal[CFG_SENS_BASE];
      c2 = cal[CFG_OFFSET_BASE];
      c3 = cal[CFG_SENS_TEMPCO];
      c4 = cal[CFG_OFFSET_TEMPCO];
      c5 = cal[CFG_REF_TEMP];
      c6 = cal[CFG_TEMP_SLOPE];

      dt   = raw_l - (c5 << REF_TEMP_SH);
      off  = (c2 << OFF_BASE_SH) + (c4 * dt) / (64'sd1 << OFF_TC_SH);
      sens = (c1 << SENS_BASE_SH) + (c3 * dt) / (64'sd1 << SENS_TC_SH);
      temp = TEMP_REF_CENTI + (dt * c6) / TEMP_DIV;

      off2  = 0;
      sens2 = 0;
      t2    = 0;
      // second-order terms below 20 degrees, with a further step below -15
      if (temp < TEMP_REF_CENTI) begin
        d     = temp - TEMP_REF_CENTI;
        off2  = 5 * (d * d) / 2;
        sens2 = 5 * (d * d) / 4;
        t2    = (dt * dt) / T2_DIV;
        n_cold++;
      end
      if (temp < TEMP_LOW_CENTI) begin
        d     = temp - TEMP_LOW_CENTI;
        off2  = off2 + 7 * (d * d);
        sens2 = sens2 + 11 * (d * d) / 2;
        n_very_cold++;
      end
      off  = off - off2;
      sens = sens - sens2;
      temp = temp - t2;

      press = ((pres_l * sens) / SENS_DIV - off) / PRESS_DIV;
      if (press > S32_MAX) press = S32_MAX;
      if (press < S32_MIN) press = S32_MIN;

      r.temp_centi = temp[TEMP_W-1:0];
      r.press_pa   = press[PRESS_W-1:0];
      r.dt         = dt[DT_W-1:0];
      return r;
    endfunction

    function void note_sample(logic cmd, logic [RAW_W-1:0] raw);
      if (cmd == CMD_PRESSURE) begin
        stored_pressure = raw;
        n_pressure++;
      end else begin
        expected_readings.push_back(compensate(raw));
        n_temperature++;
      end
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] temp_centi,
                               logic signed [PRESS_W-1:0] press_pa,
                               logic signed [DT_W-1:0] dt);
      reading_t e;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: temperature %0d, pressure %0d, delta %0d",
                 $time, temp_centi, press_pa, dt);
        return;
      end
      e = expected_readings.pop_front();
      n_checked++;
      if (temp_centi !== e.temp_centi) report("temperature_centi", e.temp_centi, temp_centi);
      if (press_pa !== e.press_pa) report("pressure_pa", e.press_pa, press_pa);
      if (dt !== e.dt) report("temp_delta", e.dt, dt);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CAL_W-1:0] cfg_wdata;

  btc_in_if  in_if ();
  btc_out_if out_if ();

  barometer_temperature_compensation DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  reading_checker sb = new();

  int src_idle_pct;
  int sink_idle_pct;
  bit sink_hold_req;
  int n_settings;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_sample(in_if.command, in_if.raw_sample);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.temperature_centi, out_if.pressure_pa, out_if.temp_delta);
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_sample(input logic cmd, input logic [RAW_W-1:0] raw);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.raw_sample <= raw;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // drop valid and wait until every reading is back and the pipe is quiet
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.write_cal(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_cal(input logic [CAL_W-1:0] sens_base, input logic [CAL_W-1:0] off_base,
                          input logic [CAL_W-1:0] sens_tc, input logic [CAL_W-1:0] off_tc,
                          input logic [CAL_W-1:0] ref_temp, input logic [CAL_W-1:0] slope);
    wait_idle();
    cfg_write(CFG_SENS_BASE, sens_base);
    cfg_write(CFG_OFFSET_BASE, off_base);
    cfg_write(CFG_SENS_TEMPCO, sens_tc);
    cfg_write(CFG_OFFSET_TEMPCO, off_tc);
    cfg_write(CFG_REF_TEMP, ref_temp);
    cfg_write(CFG_TEMP_SLOPE, slope);
    // out-of-range indexes must be dropped
    cfg_write(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, CAL_W'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    int unsigned sel;
    logic [31:0] w;
    longint      v, span;
    sel = $urandom_range(99);
    w   = $urandom;
    if (sel < 40) return w[RAW_W-1:0];
    if (sel < 45) return RAW_W'($urandom_range(255));
    if (sel < 50) return RAW_W'(RAW_MAX - $urandom_range(255));
    // cluster around the reference so every temperature branch is hit
    span = $urandom_range(1 << 22);
    v    = (longint'(sb.cal[CFG_REF_TEMP]) << REF_TEMP_SH) + span - (64'sd1 << 21);
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  task automatic random_run(input int n_items);
    int sent;
    int sel;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        send_sample(CMD_PRESSURE, pick_raw());
        send_sample(CMD_TEMPERATURE, pick_raw());
        sent += 2;
      end else if (sel < 85) begin
        send_sample(CMD_TEMPERATURE, pick_raw());
        sent++;
      end else begin
        send_sample(CMD_PRESSURE, pick_raw());
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int phase);
    int i;
    case (phase)
      0: load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      1: load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      2: load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      3: load_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
                  CAL_W'($urandom), CAL_W'($urandom), 16'hFFFF);
      default: load_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
                        CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom));
    endcase
    case (phase)
      1: begin
        // no idling on either side for this stretch
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_run(PHASE_ITEMS);
      end
      3: begin
        random_run(PHASE_ITEMS / 2);
        // hold the receiver off while samples keep coming
        sink_hold_req = 1'b1;
        src_idle_pct  = 0;
        for (i = 0; i < 40; i++) send_sample(CMD_TEMPERATURE, pick_raw());
        src_idle_pct = 30;
        random_run(PHASE_ITEMS / 2 - 40);
      end
      4: begin
        random_run(PHASE_ITEMS / 2);
        wait_idle();
        random_run(PHASE_ITEMS / 2);
      end
      default: random_run(PHASE_ITEMS);
    endcase
    src_idle_pct  = 30;
    sink_idle_pct = 30;
  endtask

  initial begin
    int p;
    rst_ni           = 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_SENS_BASE;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_PRESSURE;
    in_if.raw_sample <= '0;
    src_idle_pct     = 30;
    sink_idle_pct    = 30;
    sink_hold_req    = 1'b0;
    n_settings       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration, nothing stored yet
    send_sample(CMD_TEMPERATURE, 24'd0);
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_sample(CMD_TEMPERATURE, 24'd8569150);
    send_sample(CMD_PRESSURE, 24'd9085466);
    send_sample(CMD_TEMPERATURE, 24'd8569150);
    send_sample(CMD_PRESSURE, 24'hFFFFFF);
    send_sample(CMD_TEMPERATURE, 24'hFFFFFF);
    send_sample(CMD_TEMPERATURE, 24'd0);
    send_sample(CMD_PRESSURE, 24'd0);
    send_sample(CMD_TEMPERATURE, 24'd8566784);
    send_sample(CMD_PRESSURE, 24'hFFFFFF);
    send_sample(CMD_TEMPERATURE, 24'd8566783);
    // either side of -15 degrees
    send_sample(CMD_TEMPERATURE, 24'd7529000);
    send_sample(CMD_TEMPERATURE, 24'd7531000);
    send_sample(CMD_PRESSURE, 24'h555555);
    send_sample(CMD_TEMPERATURE, 24'hAAAAAA);
    send_sample(CMD_PRESSURE, 24'hAAAAAA);
    send_sample(CMD_TEMPERATURE, 24'h555555);
    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(CMD_PRESSURE, 24'hFFFFFF);
    send_sample(CMD_TEMPERATURE, 24'd0);
    send_sample(CMD_TEMPERATURE, 24'hFFFFFF);
    send_sample(CMD_PRESSURE, 24'd0);
    send_sample(CMD_TEMPERATURE, 24'd0);

    for (p = 0; p < 6; p++) random_phase(p);

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb: %0d pressure and %0d temperature samples sent, %0d readings checked",
             sb.n_pressure, sb.n_temperature, sb.n_checked);
    $display("tb: %0d calibration settings; %0d readings below 20 C, %0d below -15 C",
             n_settings, sb.n_cold, sb.n_very_cold);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
